/* rtl/ttiu_pkg.sv */
// Shared types and constants for the thermistor table interpolator.
`timescale 1ns / 1ps

package ttiu_pkg;

    localparam int RAW_W  = 16;
    localparam int ENT_W  = 32;
    localparam int DIFF_W = 17;
    localparam int PROD_W = 34;
    localparam int NUM_W  = 38;
    localparam int REM_W  = 17;
    localparam int SUM_W  = 40;
    localparam int OUT_W  = 24;
    localparam int CFG_W  = 7;
    localparam int IDX_W  = 6;

    localparam logic CMD_LOAD    = 1'b0;
    localparam logic CMD_CONVERT = 1'b1;

    localparam logic signed [SUM_W-1:0] OUT_MAX = SUM_W'(8388607);
    localparam logic signed [SUM_W-1:0] OUT_MIN = -SUM_W'(8388608);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_WALK,
        ST_DIFF,
        ST_MUL,
        ST_DIVGO,
        ST_DIV,
        ST_OUT
    } state_t;

    typedef struct packed {
        logic              start;
        logic [NUM_W-1:0]  dividend;
        logic [REM_W-1:0]  divisor;
    } div_req_t;

    typedef struct packed {
        logic              busy;
        logic              done;
    } div_stat_t;

endpackage

/* rtl/ttiu_table_ram.sv */
// Curve table memory: one write port, one registered read port.
`timescale 1ns / 1ps

module ttiu_table_ram #(
    parameter int DEPTH = 64
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [$clog2(DEPTH)-1:0]    wr_addr,
    input  logic [ttiu_pkg::ENT_W-1:0]  wr_data,
    input  logic                        rd_en,
    input  logic [$clog2(DEPTH)-1:0]    rd_addr,
    output logic [ttiu_pkg::ENT_W-1:0]  rd_data
);

    logic [ttiu_pkg::ENT_W-1:0] mem [DEPTH];
    logic [ttiu_pkg::ENT_W-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* rtl/ttiu_divider.sv */
// Restoring unsigned divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module ttiu_divider (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  ttiu_pkg::div_req_t          req,
    output ttiu_pkg::div_stat_t         stat,
    output logic [ttiu_pkg::NUM_W-1:0]  quotient
);

    localparam int CNT_W = $clog2(ttiu_pkg::NUM_W);

    logic                        busy_reg, busy_next;
    logic                        done_reg, done_next;
    logic [CNT_W-1:0]            cnt_reg, cnt_next;
    logic [ttiu_pkg::REM_W-1:0]  rem_reg, rem_next;
    logic [ttiu_pkg::REM_W-1:0]  den_reg, den_next;
    logic [ttiu_pkg::NUM_W-1:0]  quo_reg, quo_next;
    logic [ttiu_pkg::REM_W:0]    trial;
    logic [ttiu_pkg::REM_W:0]    diff;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        quo_next  = quo_reg;
        // dividend bits shift out of the top while quotient bits shift in
        trial     = {rem_reg, quo_reg[ttiu_pkg::NUM_W-1]};
        diff      = trial - {1'b0, den_reg};
        if (req.start && !busy_reg) begin
            busy_next = 1'b1;
            cnt_next  = CNT_W'(ttiu_pkg::NUM_W - 1);
            rem_next  = '0;
            den_next  = req.divisor;
            quo_next  = req.dividend;
        end else if (busy_reg) begin
            if (!diff[ttiu_pkg::REM_W]) begin
                rem_next = diff[ttiu_pkg::REM_W-1:0];
                quo_next = {quo_reg[ttiu_pkg::NUM_W-2:0], 1'b1};
            end else begin
                rem_next = trial[ttiu_pkg::REM_W-1:0];
                quo_next = {quo_reg[ttiu_pkg::NUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == '0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        den_reg <= den_next;
        quo_reg <= quo_next;
    end

    assign stat.busy = busy_reg;
    assign stat.done = done_reg;
    assign quotient  = quo_reg;

endmodule

/* rtl/thermistor_table_interpolator_unit.sv */
// Top level: table walk, interpolation sequencer and result register.
//
//  channel | ports                                            | handshake
//  --------+--------------------------------------------------+-----------------
//  input   | s_cmd s_entry_index s_entry_raw s_entry_temp     | s_valid/s_ready
//          | s_raw_sample                                     |
//  result  | m_temperature m_above_table m_flat_segment       | m_valid/m_ready
//          | m_saturated                                      |
//  config  | cfg_wr_data (table_length)                       | cfg_wr_en
//
// A load item writes the table memory directly.
// A convert item walks the table through the single memory read port, one entry
// a cycle until a hit or the last entry, then takes the difference, multiply,
// divider start and serial divider steps, forms the sum and loads the output
// register; a flat segment or a sample above the table skips to the output
// register. The next item is taken once the result sits in the output register;
// a stalled result holds only the last stage.
// Synchronous active-low reset; table contents are not cleared.
`timescale 1ns / 1ps

module thermistor_table_interpolator_unit #(
    parameter int TABLE_DEPTH = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           cfg_wr_en,
    input  logic [ttiu_pkg::CFG_W-1:0]     cfg_wr_data,
    input  logic                           s_valid,
    output logic                           s_ready,
    input  logic                           s_cmd,
    input  logic [ttiu_pkg::IDX_W-1:0]     s_entry_index,
    input  logic signed [ttiu_pkg::RAW_W-1:0] s_entry_raw,
    input  logic signed [ttiu_pkg::RAW_W-1:0] s_entry_temp,
    input  logic signed [ttiu_pkg::RAW_W-1:0] s_raw_sample,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic signed [ttiu_pkg::OUT_W-1:0] m_temperature,
    output logic                           m_above_table,
    output logic                           m_flat_segment,
    output logic                           m_saturated
);

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int LW = AW + 1;
    localparam int CW = AW + ttiu_pkg::IDX_W;

    localparam int RW  = ttiu_pkg::RAW_W;
    localparam int EW  = ttiu_pkg::ENT_W;
    localparam int DW  = ttiu_pkg::DIFF_W;
    localparam int PW  = ttiu_pkg::PROD_W;
    localparam int NW  = ttiu_pkg::NUM_W;
    localparam int SW  = ttiu_pkg::SUM_W;
    localparam int OW  = ttiu_pkg::OUT_W;

    ttiu_pkg::state_t state_reg, state_next;

    logic [ttiu_pkg::CFG_W-1:0] table_length_reg;

    logic [LW-1:0]          len_reg, len_next;
    logic [AW-1:0]          last_reg, last_next;
    logic [LW-1:0]          issue_reg, issue_next;
    logic                   pend_reg, pend_next;
    logic [AW-1:0]          pend_idx_reg, pend_idx_next;
    logic signed [RW-1:0]   sample_reg, sample_next;
    logic [EW-1:0]          prev_reg, prev_next;
    logic [EW-1:0]          lo_reg, lo_next;
    logic [EW-1:0]          hi_reg, hi_next;
    logic signed [DW-1:0]   span_reg, span_next;
    logic signed [DW-1:0]   dr_reg, dr_next;
    logic signed [DW-1:0]   dt_reg, dt_next;
    logic signed [PW-1:0]   prod_reg, prod_next;
    logic                   neg_reg, neg_next;
    logic [OW-1:0]          res_temp_reg, res_temp_next;
    logic                   res_above_reg, res_above_next;
    logic                   res_flat_reg, res_flat_next;
    logic                   res_sat_reg, res_sat_next;
    logic                   m_valid_reg, m_valid_next;
    logic [OW-1:0]          m_temp_reg, m_temp_next;
    logic                   m_above_reg, m_above_next;
    logic                   m_flat_reg, m_flat_next;
    logic                   m_sat_reg, m_sat_next;

    logic                   wr_en;
    logic [CW-1:0]          wr_idx_ext;
    logic                   rd_en;
    logic [EW-1:0]          rd_data;
    logic [CW-1:0]          tl_ext;
    logic [LW-1:0]          len_eff;
    logic [LW-1:0]          len_m1;

    ttiu_pkg::div_req_t     div_req;
    ttiu_pkg::div_stat_t    div_stat;
    logic [NW-1:0]          div_quo;

    logic [DW-1:0]          span_mag;
    logic [PW-1:0]          prod_mag;
    logic [NW:0]            q_signed;
    logic signed [SW-1:0]   sum;

    ttiu_table_ram #(
        .DEPTH(TABLE_DEPTH)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_idx_ext[AW-1:0]),
        .wr_data ({s_entry_raw, s_entry_temp}),
        .rd_en   (rd_en),
        .rd_addr (issue_reg[AW-1:0]),
        .rd_data (rd_data)
    );

    ttiu_divider u_div (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .req      (div_req),
        .stat     (div_stat),
        .quotient (div_quo)
    );

    // whole degrees to 1/16 degree, sign extended to the output width
    function automatic logic [ttiu_pkg::OUT_W-1:0] x16(input logic [ttiu_pkg::RAW_W-1:0] t);
        x16 = {{(ttiu_pkg::OUT_W - ttiu_pkg::RAW_W - 4){t[ttiu_pkg::RAW_W-1]}}, t, 4'b0000};
    endfunction

    assign wr_idx_ext = CW'(s_entry_index);
    assign tl_ext     = CW'(table_length_reg);

    always_comb begin
        if (table_length_reg == '0) begin
            len_eff = LW'(1);
        end else if (tl_ext > CW'(TABLE_DEPTH)) begin
            len_eff = LW'(TABLE_DEPTH);
        end else begin
            len_eff = LW'(tl_ext);
        end
        len_m1 = len_eff - 1'b1;
    end

    assign span_mag = span_reg[DW-1] ? DW'(-span_reg) : DW'(span_reg);
    assign prod_mag = prod_reg[PW-1] ? PW'(-prod_reg) : PW'(prod_reg);

    always_comb begin
        q_signed = neg_reg ? (NW+1)'(-{1'b0, div_quo}) : {1'b0, div_quo};
        sum = $signed(SW'({{(SW-NW-1){q_signed[NW]}}, q_signed}))
            + $signed(SW'({{(SW-RW-4){lo_reg[RW-1]}}, lo_reg[RW-1:0], 4'b0000}));
    end

    always_comb begin
        state_next     = state_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        issue_next     = issue_reg;
        pend_next      = pend_reg;
        pend_idx_next  = pend_idx_reg;
        sample_next    = sample_reg;
        prev_next      = prev_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        span_next      = span_reg;
        dr_next        = dr_reg;
        dt_next        = dt_reg;
        prod_next      = prod_reg;
        neg_next       = neg_reg;
        res_temp_next  = res_temp_reg;
        res_above_next = res_above_reg;
        res_flat_next  = res_flat_reg;
        res_sat_next   = res_sat_reg;
        m_valid_next   = m_valid_reg;
        m_temp_next    = m_temp_reg;
        m_above_next   = m_above_reg;
        m_flat_next    = m_flat_reg;
        m_sat_next     = m_sat_reg;
        s_ready        = 1'b0;
        wr_en          = 1'b0;
        rd_en          = 1'b0;
        div_req.start    = 1'b0;
        div_req.dividend = {prod_mag, 4'b0000};
        div_req.divisor  = span_mag;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ttiu_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    if (s_cmd == ttiu_pkg::CMD_LOAD) begin
                        wr_en = (wr_idx_ext < CW'(TABLE_DEPTH));
                    end else begin
                        sample_next = s_raw_sample;
                        len_next    = len_eff;
                        last_next   = len_m1[AW-1:0];
                        issue_next  = '0;
                        pend_next   = 1'b0;
                        state_next  = ttiu_pkg::ST_WALK;
                    end
                end
            end
            ttiu_pkg::ST_WALK: begin
                // reads run one ahead of the compare
                pend_next = 1'b0;
                if (issue_reg < len_reg) begin
                    rd_en         = 1'b1;
                    issue_next    = issue_reg + 1'b1;
                    pend_next     = 1'b1;
                    pend_idx_next = issue_reg[AW-1:0];
                end
                if (pend_reg) begin
                    if (pend_idx_reg != '0 &&
                        $signed(rd_data[EW-1:RW]) > sample_reg) begin
                        hi_next    = rd_data;
                        lo_next    = prev_reg;
                        state_next = ttiu_pkg::ST_DIFF;
                    end else if (pend_idx_reg == last_reg) begin
                        res_temp_next  = x16(rd_data[RW-1:0]);
                        res_above_next = 1'b1;
                        res_flat_next  = 1'b0;
                        res_sat_next   = 1'b0;
                        state_next     = ttiu_pkg::ST_OUT;
                    end else begin
                        prev_next = rd_data;
                    end
                end
            end
            ttiu_pkg::ST_DIFF: begin
                span_next = $signed({hi_reg[EW-1], hi_reg[EW-1:RW]})
                          - $signed({lo_reg[EW-1], lo_reg[EW-1:RW]});
                dr_next   = $signed({sample_reg[RW-1], sample_reg})
                          - $signed({lo_reg[EW-1], lo_reg[EW-1:RW]});
                dt_next   = $signed({hi_reg[RW-1], hi_reg[RW-1:0]})
                          - $signed({lo_reg[RW-1], lo_reg[RW-1:0]});
                if (hi_reg[EW-1:RW] == lo_reg[EW-1:RW]) begin
                    res_temp_next  = x16(hi_reg[RW-1:0]);
                    res_above_next = 1'b0;
                    res_flat_next  = 1'b1;
                    res_sat_next   = 1'b0;
                    state_next     = ttiu_pkg::ST_OUT;
                end else begin
                    state_next = ttiu_pkg::ST_MUL;
                end
            end
            ttiu_pkg::ST_MUL: begin
                prod_next  = PW'(dr_reg * dt_reg);
                state_next = ttiu_pkg::ST_DIVGO;
            end
            ttiu_pkg::ST_DIVGO: begin
                div_req.start = 1'b1;
                neg_next      = prod_reg[PW-1] ^ span_reg[DW-1];
                state_next    = ttiu_pkg::ST_DIV;
            end
            ttiu_pkg::ST_DIV: begin
                if (div_stat.done) begin
                    res_above_next = 1'b0;
                    res_flat_next  = 1'b0;
                    if (sum > ttiu_pkg::OUT_MAX) begin
                        res_temp_next = OW'(ttiu_pkg::OUT_MAX);
                        res_sat_next  = 1'b1;
                    end else if (sum < ttiu_pkg::OUT_MIN) begin
                        res_temp_next = OW'(ttiu_pkg::OUT_MIN);
                        res_sat_next  = 1'b1;
                    end else begin
                        res_temp_next = sum[OW-1:0];
                        res_sat_next  = 1'b0;
                    end
                    state_next = ttiu_pkg::ST_OUT;
                end
            end
            ttiu_pkg::ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next = 1'b1;
                    m_temp_next  = res_temp_reg;
                    m_above_next = res_above_reg;
                    m_flat_next  = res_flat_reg;
                    m_sat_next   = res_sat_reg;
                    state_next   = ttiu_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = ttiu_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg        <= ttiu_pkg::ST_IDLE;
            table_length_reg <= ttiu_pkg::CFG_W'(1);
            pend_reg         <= 1'b0;
            m_valid_reg      <= 1'b0;
        end else begin
            state_reg   <= state_next;
            pend_reg    <= pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_wr_en) begin
                table_length_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        len_reg       <= len_next;
        last_reg      <= last_next;
        issue_reg     <= issue_next;
        pend_idx_reg  <= pend_idx_next;
        sample_reg    <= sample_next;
        prev_reg      <= prev_next;
        lo_reg        <= lo_next;
        hi_reg        <= hi_next;
        span_reg      <= span_next;
        dr_reg        <= dr_next;
        dt_reg        <= dt_next;
        prod_reg      <= prod_next;
        neg_reg       <= neg_next;
        res_temp_reg  <= res_temp_next;
        res_above_reg <= res_above_next;
        res_flat_reg  <= res_flat_next;
        res_sat_reg   <= res_sat_next;
        m_temp_reg    <= m_temp_next;
        m_above_reg   <= m_above_next;
        m_flat_reg    <= m_flat_next;
        m_sat_reg     <= m_sat_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_temperature  = m_temp_reg;
    assign m_above_table  = m_above_reg;
    assign m_flat_segment = m_flat_reg;
    assign m_saturated    = m_sat_reg;

endmodule
